>>> rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, constants and angle table for the pure pursuit steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int COORD_BITS_DEF   = 24;
    localparam int CORDIC_STEPS_DEF = 20;

    localparam int NORM_HI   = 40;
    localparam int CW        = 44;   // CORDIC x/y width (2^40 grown by gain, plus sign)
    localparam int ZW        = 28;   // angle accumulator width
    localparam int ANG_FRAC  = 12;
    localparam int MAX_CD    = 9000;
    localparam int RAD_TO_ANG = 23468351;

    typedef enum logic [1:0] {
        CMD_POINT = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_WHEELBASE = 2'd0,
        REG_LOOKAHEAD = 2'd1,
        REG_STEER_LIM = 2'd2,
        REG_FWD_ONLY  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_NORM,
        ST_ITER,
        ST_ROUND,
        ST_OUT
    } eng_state_t;

    // Atan of 2^-i in 1/4096 centidegree units, rounded to nearest.
    function automatic logic [ZW-1:0] atan_step(input logic [5:0] i);
        logic [ZW-1:0] r;
        unique case (i)
            6'd0: r = ZW'(18432000);
            6'd1: r = ZW'(10881045);
            6'd2: r = ZW'(5749245);
            6'd3: r = ZW'(2918407);
            6'd4: r = ZW'(1464867);
            6'd5: r = ZW'(733147);
            6'd6: r = ZW'(366663);
            6'd7: r = ZW'(183343);
            6'd8: r = ZW'(91673);
            6'd9: r = ZW'(45837);
            default: r = ZW'((64'(RAD_TO_ANG) + (64'd1 << (i - 6'd1))) >> i);
        endcase
        return r;
    endfunction

endpackage

>>> rtl/pps_front.sv
// ----------------------------------------------------------------------------
// pps_front
// Accepts path items, keeps the running look-ahead target choice and pushes
// a target job into the queue for each tick.
// ----------------------------------------------------------------------------
module pps_front #(
    parameter int COORD_BITS = pps_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_command,
    input  logic signed [COORD_BITS-1:0] s_point_x,
    input  logic signed [COORD_BITS-1:0] s_point_y,
    input  logic [15:0]                  lookahead_distance,
    input  logic                         fwd_only,
    input  logic                         q_full,
    output logic                         q_push,
    output logic [2*COORD_BITS:0]        q_data
);
    import pps_pkg::*;

    localparam int SQW = 2*COORD_BITS + 1;

    logic found_reg, fwd_seen_reg, any_reg;
    logic signed [COORD_BITS-1:0] ch_x_reg, ch_y_reg, lf_x_reg, lf_y_reg, l_x_reg, l_y_reg;

    // Reach test pipeline stage: point and squares registered
    logic                         p_valid_reg;
    logic                         p_elig_reg;
    logic signed [COORD_BITS-1:0] p_x_reg, p_y_reg;
    logic [SQW-1:0]               p_r2_reg;
    logic [31:0]                  p_l2_reg;

    logic [COORD_BITS-1:0] ax, ay;
    logic                  acc, is_tick, is_point, is_clear;
    logic                  take_tick;

    assign ax = s_point_x[COORD_BITS-1] ? COORD_BITS'(-s_point_x) : COORD_BITS'(s_point_x);
    assign ay = s_point_y[COORD_BITS-1] ? COORD_BITS'(-s_point_y) : COORD_BITS'(s_point_y);

    // Hold ticks while the queue is full or a point is still resolving
    assign s_ready  = !(s_command == CMD_TICK && (q_full || p_valid_reg));
    assign acc      = s_valid && s_ready;
    assign is_point = acc && (s_command == CMD_POINT);
    assign is_tick  = acc && (s_command == CMD_TICK);
    assign is_clear = acc && (s_command == CMD_CLEAR);
    assign take_tick = is_tick;

    // Register a point with its squared range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= is_point;
        end
        p_x_reg    <= s_point_x;
        p_y_reg    <= s_point_y;
        p_elig_reg <= !fwd_only || (!s_point_x[COORD_BITS-1] && s_point_x != '0);
        p_r2_reg   <= SQW'(ax * ax) + SQW'(ay * ay);
        p_l2_reg   <= lookahead_distance * lookahead_distance;
    end

    // Update the path summary
    always_ff @(posedge aclk) begin
        if (!aresetn || is_clear) begin
            found_reg    <= 1'b0;
            fwd_seen_reg <= 1'b0;
            any_reg      <= 1'b0;
            ch_x_reg <= '0; ch_y_reg <= '0;
            lf_x_reg <= '0; lf_y_reg <= '0;
            l_x_reg  <= '0; l_y_reg  <= '0;
        end else if (p_valid_reg) begin
            any_reg <= 1'b1;
            l_x_reg <= p_x_reg;
            l_y_reg <= p_y_reg;
            if (!p_x_reg[COORD_BITS-1] && p_x_reg != '0) begin
                fwd_seen_reg <= 1'b1;
                lf_x_reg <= p_x_reg;
                lf_y_reg <= p_y_reg;
            end
            if (!found_reg && p_elig_reg && p_r2_reg >= SQW'(p_l2_reg)) begin
                found_reg <= 1'b1;
                ch_x_reg  <= p_x_reg;
                ch_y_reg  <= p_y_reg;
            end
        end
    end

    // Pick the target for a tick
    always_comb begin
        logic signed [COORD_BITS-1:0] tx, ty;
        tx = '0;
        ty = '0;
        if (any_reg) begin
            if (found_reg) begin
                tx = ch_x_reg; ty = ch_y_reg;
            end else if (fwd_only && fwd_seen_reg) begin
                tx = lf_x_reg; ty = lf_y_reg;
            end else begin
                tx = l_x_reg; ty = l_y_reg;
            end
        end
        q_push = take_tick;
        q_data = {any_reg, tx, ty};
    end

endmodule

>>> rtl/pps_queue.sv
// ----------------------------------------------------------------------------
// pps_queue
// Small register FIFO between the front and the CORDIC engine.
// ----------------------------------------------------------------------------
module pps_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign pop_data  = mem_reg[rp_reg];

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push && !full) wp_reg <= ~wp_reg;
            if (pop && not_empty) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(pop && not_empty);
        end
        if (push && !full) mem_reg[wp_reg] <= push_data;
    end

endmodule

>>> rtl/pps_engine.sv
// ----------------------------------------------------------------------------
// pps_engine
// Computes the clamped steering angle for one target by a vectoring CORDIC,
// one rotation per cycle, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module pps_engine #(
    parameter int COORD_BITS   = pps_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = pps_pkg::CORDIC_STEPS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         job_valid,
    input  logic [2*COORD_BITS:0]        job_data,
    output logic                         job_pop,
    input  logic [15:0]                  wheelbase,
    input  logic [13:0]                  steer_limit,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [14:0]           m_steer_angle,
    output logic signed [COORD_BITS-1:0] m_target_x,
    output logic signed [COORD_BITS-1:0] m_target_y,
    output logic                         m_target_valid
);
    import pps_pkg::*;

    localparam int MW = 2*COORD_BITS + 1;       // den/num width
    localparam int SW = (MW > CW) ? MW : CW;     // normalize work width

    eng_state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] tx_reg, ty_reg;
    logic                         tv_reg;
    logic [SW-1:0]                den_reg, num_reg;
    logic signed [CW-1:0]         cx_reg, cy_reg;
    logic signed [ZW-1:0]         z_reg;
    logic [5:0]                   i_reg;
    logic signed [14:0]           ang_reg;
    logic                         zero_reg;

    logic [COORD_BITS-1:0] ax, ay;
    logic [SW-1:0]         mx;
    logic signed [CW-1:0]  dx, dy;
    logic signed [ZW-1:0]  a;
    logic [ZW-1:0]         zm, r;
    logic [13:0]           lim;

    assign ax = tx_reg[COORD_BITS-1] ? COORD_BITS'(-tx_reg) : COORD_BITS'(tx_reg);
    assign ay = ty_reg[COORD_BITS-1] ? COORD_BITS'(-ty_reg) : COORD_BITS'(ty_reg);
    assign mx = (den_reg > num_reg) ? den_reg : num_reg;
    assign dx = cy_reg >>> i_reg;
    assign dy = cx_reg >>> i_reg;
    assign a  = ZW'(atan_step(i_reg));
    assign zm = z_reg[ZW-1] ? ZW'(-z_reg) : ZW'(z_reg);
    assign r  = (zm + ZW'(1 << (ANG_FRAC-1))) >> ANG_FRAC;
    assign lim = (steer_limit > 14'(MAX_CD)) ? 14'(MAX_CD) : steer_limit;

    assign job_pop        = (state_reg == ST_IDLE) && job_valid;
    assign m_valid        = state_reg == ST_OUT;
    assign m_steer_angle  = ang_reg;
    assign m_target_x     = tx_reg;
    assign m_target_y     = ty_reg;
    assign m_target_valid = tv_reg;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (job_valid) state_next = ST_MUL;
            ST_MUL:   state_next = ST_NORM;
            ST_NORM:  if (zero_reg) state_next = ST_OUT;
                      else if (mx < (SW'(1) << (NORM_HI-1))) state_next = ST_NORM;
                      else if (mx >= (SW'(1) << NORM_HI)) state_next = ST_NORM;
                      else state_next = ST_ITER;
            ST_ITER:  if (i_reg == 6'(CORDIC_STEPS-1)) state_next = ST_ROUND;
            ST_ROUND: state_next = ST_OUT;
            ST_OUT:   if (m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                tv_reg <= job_data[2*COORD_BITS];
                tx_reg <= job_data[2*COORD_BITS-1:COORD_BITS];
                ty_reg <= job_data[COORD_BITS-1:0];
                ang_reg <= '0;
            end
            ST_MUL: begin
                den_reg  <= (ax == '0 && ay == '0) ? SW'(1)
                                                   : SW'(ax * ax) + SW'(ay * ay);
                num_reg  <= SW'({wheelbase, 1'b0} * ay);
                zero_reg <= !tv_reg || wheelbase == '0 || ty_reg == '0;
            end
            ST_NORM: begin
                if (mx >= (SW'(1) << NORM_HI)) begin
                    den_reg <= den_reg >> 1; num_reg <= num_reg >> 1;
                end else if (mx < (SW'(1) << (NORM_HI-1))) begin
                    den_reg <= den_reg << 1; num_reg <= num_reg << 1;
                end
                cx_reg <= CW'(den_reg);
                cy_reg <= ty_reg[COORD_BITS-1] ? -CW'(num_reg) : CW'(num_reg);
                z_reg  <= '0;
                i_reg  <= '0;
            end
            ST_ITER: begin
                if (!cy_reg[CW-1]) begin
                    cx_reg <= cx_reg + dx; cy_reg <= cy_reg - dy; z_reg <= z_reg + a;
                end else begin
                    cx_reg <= cx_reg - dx; cy_reg <= cy_reg + dy; z_reg <= z_reg - a;
                end
                i_reg <= i_reg + 6'd1;
            end
            ST_ROUND: begin
                logic [ZW-1:0] rc;
                rc = (r > ZW'(lim)) ? ZW'(lim) : r;
                ang_reg <= z_reg[ZW-1] ? -15'(rc) : 15'(rc);
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    // Result only shows in the output state and holds there
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_steer_angle))
        else $error("result changed while stalled");
    a_lim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_steer_angle <= 15'sd9000 && m_steer_angle >= -15'sd9000))
        else $error("angle out of range");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_target_valid |-> m_steer_angle == '0)
        else $error("empty path gave nonzero angle");

endmodule

>>> rtl/pure_pursuit_steering.sv
// ----------------------------------------------------------------------------
// pure_pursuit_steering
// Pure pursuit steering: streamed path points, look-ahead target choice and
// CORDIC steering angle in centidegrees.
// ----------------------------------------------------------------------------
// Path points and clear commands are taken one per cycle. A tick pushes the
// current target into a two-entry queue; per tick the CORDIC engine then
// forms the squares, normalizes them one shift at a time, runs CORDIC_STEPS
// rotations one per cycle, then rounds and clamps the angle. A tick is held
// while a point is in the reach test stage and while the queue is full.
module pure_pursuit_steering #(
    parameter int COORD_BITS   = pps_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = pps_pkg::CORDIC_STEPS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_command,
    input  logic signed [COORD_BITS-1:0] s_point_x,
    input  logic signed [COORD_BITS-1:0] s_point_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [14:0]           m_steer_angle,
    output logic signed [COORD_BITS-1:0] m_target_x,
    output logic signed [COORD_BITS-1:0] m_target_y,
    output logic                         m_target_valid
);
    import pps_pkg::*;

    localparam int QW = 2*COORD_BITS + 1;

    logic [15:0] wheelbase_reg, lookahead_reg;
    logic [13:0] steer_lim_reg;
    logic        fwd_only_reg;
    logic        q_full, q_push, q_ne, q_pop;
    logic [QW-1:0] q_in, q_out;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheelbase_reg <= 16'd1295;
            lookahead_reg <= 16'd2500;
            steer_lim_reg <= 14'd3000;
            fwd_only_reg  <= 1'b1;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_WHEELBASE: wheelbase_reg <= cfg_data;
                REG_LOOKAHEAD: lookahead_reg <= cfg_data;
                REG_STEER_LIM: steer_lim_reg <= cfg_data[13:0];
                REG_FWD_ONLY:  fwd_only_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    pps_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command, .s_point_x, .s_point_y,
        .lookahead_distance(lookahead_reg), .fwd_only(fwd_only_reg),
        .q_full, .q_push, .q_data(q_in)
    );

    pps_queue #(.WIDTH(QW)) u_queue (
        .aclk, .aresetn, .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .pop_data(q_out)
    );

    pps_engine #(.COORD_BITS(COORD_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_engine (
        .aclk, .aresetn, .job_valid(q_ne), .job_data(q_out), .job_pop(q_pop),
        .wheelbase(wheelbase_reg), .steer_limit(steer_lim_reg),
        .m_valid, .m_ready, .m_steer_angle, .m_target_x, .m_target_y, .m_target_valid
    );

endmodule
